// ----- hw/rtl/bba_pkg.sv -----
// shared constants and types for the buddy block allocator
`default_nettype none
package bba_pkg;
   localparam int Levels = 6;
   localparam int NBlk = 1 << Levels;
   localparam int IdxW = Levels;
   localparam int OrdW = $clog2(Levels + 2);
   localparam int LvlW = $clog2(Levels + 1);
   localparam int AoW = 4;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_NOFIT = 2'd1;
   localparam logic [1:0] STATUS_BADFREE = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   localparam logic CSR_BLOCK_SHIFT = 1'b0;
   localparam logic CSR_HEADER_BYTES = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_ASCAN  = 8'b0000_0010,
      ST_ASPLIT = 8'b0000_0100,
      ST_FLOOK  = 8'b0000_1000,
      ST_FMERGE = 8'b0001_0000,
      ST_FPUT   = 8'b0010_0000,
      ST_RESP   = 8'b0100_0000,
      ST_ACHK   = 8'b1000_0000
   } state_type;
endpackage
`default_nettype wire

// ----- hw/rtl/bba_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none
module bba_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/buddy_block_allocator_core.sv -----
// buddy block allocator top level
// one request at a time; allocate finds the order it needs, scans the free lists up from
// that level, then splits one block per level back down; free looks up the stored order,
// then takes one merge step per level while the buddy is free; the level walk sets the pace
// result waits in an output register, next request accepted once it is taken
// synchronous reset restores the full arena free, nothing allocated, at once
// (free lists in flip-flops, alloc table covered by per-entry valid bits)
`default_nettype none
module buddy_block_allocator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [0] opcode, [18:1] request_bytes, [36:19] payload_offset
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] status, [19:2] granted_offset
   output logic      [23:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_wdata
);
   import bba_pkg::*;

   state_type state_ff, state_in;
   logic [3:0] shift_ff, shift_in;
   logic [6:0] hdr_ff, hdr_in;
   logic [NBlk-1:0] free_ff [Levels+1];
   logic [NBlk-1:0] free_in [Levels+1];
   logic [NBlk-1:0] aval_ff, aval_in;
   logic [LvlW-1:0] k_ff, k_in;
   logic [LvlW-1:0] ord_ff, ord_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [19:0] blocks_ff, blocks_in;
   logic [1:0] status_ff, status_in;
   logic [17:0] goff_ff, goff_in;
   logic rvalid_ff, rvalid_in;

   logic ram_we;
   logic [IdxW-1:0] ram_waddr, ram_raddr;
   logic [AoW-1:0] ram_wdata, ram_rdata;

   bba_ram #(.Width(AoW), .Depth(NBlk)) u_order_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_addr(ram_raddr), .rd_data(ram_rdata)
   );

   logic [3:0] sh;
   logic [18:0] total;
   logic [19:0] rnd;
   logic [19:0] blk;
   logic [17:0] base;
   logic [17:0] bmask;
   logic [17:0] bshift;
   logic [NBlk-1:0] fk;
   logic [IdxW-1:0] low;
   logic [IdxW-1:0] bud;
   logic [IdxW-1:0] step;
   logic [AoW-1:0] ao;
   logic found;

   always_comb begin
      sh = (shift_ff < 4'd4) ? 4'd4 : ((shift_ff > 4'd12) ? 4'd12 : shift_ff);
      total = {1'b0, req_tdata[18:1]} + {12'd0, hdr_ff};
      rnd = {1'b0, total} + ((20'd1 << sh) - 20'd1);
      blk = rnd >> sh;
      base = req_tdata[36:19] - {11'd0, hdr_ff};
      bmask = (18'd1 << sh) - 18'd1;
      bshift = base >> sh;
      fk = free_ff[k_ff];
      low = '0;
      found = 1'b0;
      for (int i = NBlk - 1; i >= 0; i--) begin
         if (fk[i]) begin
            low = IdxW'(i);
            found = 1'b1;
         end
      end
      step = IdxW'(1) << ord_ff;
      bud = idx_ff ^ step;
      ao = aval_ff[idx_ff] ? ram_rdata : '0;
   end

   always_comb begin
      state_in = state_ff;
      shift_in = shift_ff;
      hdr_in = hdr_ff;
      free_in = free_ff;
      aval_in = aval_ff;
      k_in = k_ff;
      ord_in = ord_ff;
      idx_in = idx_ff;
      blocks_in = blocks_ff;
      status_in = status_ff;
      goff_in = goff_ff;
      rvalid_in = rvalid_ff;
      ram_we = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = '0;
      ram_raddr = idx_ff;
      req_tready = (state_ff == ST_IDLE) && !rvalid_ff;

      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end
      if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_SHIFT: shift_in = csr_wdata[3:0];
            CSR_HEADER_BYTES: hdr_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               status_in = STATUS_NOFIT;
               goff_in = '0;
               ord_in = '0;
               blocks_in = blk;
               if (req_tdata[0] == OP_ALLOC) begin
                  state_in = ST_ACHK;
               end else begin
                  status_in = STATUS_BADFREE;
                  idx_in = bshift[IdxW-1:0];
                  ram_raddr = bshift[IdxW-1:0];
                  if (req_tdata[36:19] < {11'd0, hdr_ff} || (base & bmask) != 18'd0
                      || bshift >= 18'(NBlk)) begin
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_FLOOK;
                  end
               end
            end
         end
         ST_ACHK: begin
            if ((20'd1 << ord_ff) >= blocks_ff) begin
               k_in = ord_ff;
               state_in = ST_ASCAN;
            end else if (ord_ff == LvlW'(Levels)) begin
               state_in = ST_RESP;
            end else begin
               ord_in = ord_ff + 1'b1;
            end
         end
         ST_ASCAN: begin
            if (found) begin
               idx_in = low;
               free_in[k_ff][low] = 1'b0;
               state_in = ST_ASPLIT;
            end else if (k_ff == LvlW'(Levels)) begin
               state_in = ST_RESP;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_ASPLIT: begin
            if (k_ff > ord_ff) begin
               free_in[k_ff-1'b1][idx_ff + (IdxW'(1) << (k_ff - 1'b1))] = 1'b1;
               k_in = k_ff - 1'b1;
            end else begin
               ram_we = 1'b1;
               ram_wdata = AoW'(ord_ff) + 1'b1;
               aval_in[idx_ff] = 1'b1;
               status_in = STATUS_DONE;
               goff_in = 18'(({12'd0, idx_ff} << sh) + {11'd0, hdr_ff});
               state_in = ST_RESP;
            end
         end
         ST_FLOOK: begin
            if (ao == '0 || ao > AoW'(Levels + 1)) begin
               state_in = ST_RESP;
            end else begin
               ord_in = LvlW'(ao - 1'b1);
               ram_we = 1'b1;
               ram_wdata = '0;
               aval_in[idx_ff] = 1'b1;
               state_in = ST_FMERGE;
            end
         end
         ST_FMERGE: begin
            if (ord_ff < LvlW'(Levels) && free_ff[ord_ff][bud]) begin
               free_in[ord_ff][bud] = 1'b0;
               if (bud < idx_ff) idx_in = bud;
               ord_in = ord_ff + 1'b1;
            end else begin
               state_in = ST_FPUT;
            end
         end
         ST_FPUT: begin
            free_in[ord_ff][idx_ff] = 1'b1;
            status_in = STATUS_DONE;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rvalid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         shift_ff <= 4'd7;
         hdr_ff <= 7'd16;
         for (int j = 0; j <= Levels; j++) begin
            free_ff[j] <= (j == Levels) ? NBlk'(1) : '0;
         end
         aval_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         shift_ff <= shift_in;
         hdr_ff <= hdr_in;
         free_ff <= free_in;
         aval_ff <= aval_in;
         rvalid_ff <= rvalid_in;
      end
      k_ff <= k_in;
      ord_ff <= ord_in;
      idx_ff <= idx_in;
      blocks_ff <= blocks_in;
      status_ff <= status_in;
      goff_ff <= goff_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata = {4'd0, goff_ff, status_ff};
endmodule
`default_nettype wire
